/* rtl/core/lmc_pkg.sv */
// Shared constants and types of the 3x3 local-maximum counter.
package lmc_pkg;

  localparam int MaxCols = 512;
  localparam int MaxRows = 512;
  localparam int SampleW = 16;
  localparam int CfgW    = 10;
  localparam int CountW  = 19;
  localparam int OutW    = ((CountW + 7) / 8) * 8;

  localparam int ColW    = $clog2(MaxCols);
  localparam int RowW    = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int PosMaxW = (ColW > RowW) ? ColW : RowW;
  localparam int PosCmpW = ((PosMaxW > CfgW) ? PosMaxW : CfgW) + 1;

  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    RegNumRows = 1'b0,
    RegNumCols = 1'b1
  } cfg_reg_e;

  // One decided item on its way from the window logic to the counter.
  typedef struct packed {
    logic       frame_end;
    logic       row_end;
    logic [1:0] inc_win;   // centres of the row above that passed
    logic [1:0] inc_last;  // centres of this row, valid if it is the last one
  } rec_t;

endpackage

/* rtl/core/lmc_front.sv */
// Front end: position tracking, two line stores, 3x3 window and centre judgement.
module lmc_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               acc_i,
  input  logic signed [lmc_pkg::SampleW-1:0] sample_i,
  input  logic [lmc_pkg::CfgW-1:0]           rows_i,
  input  logic [lmc_pkg::CfgW-1:0]           cols_i,
  output logic                               push_o,
  output lmc_pkg::rec_t                      rec_o,
  output logic [1:0]                         inflight_o
);

  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic last_col;
    logic last_row;
    logic c_in;    // column below the row length
    logic cm1_in;  // column to the left below the row length
  } pos_t;

  logic [lmc_pkg::ColW-1:0] col_q, col_d;
  logic [lmc_pkg::RowW-1:0] row_q, row_d;
  logic [lmc_pkg::PosCmpW-1:0] col_ext, row_ext, cols_ext, rows_ext;
  pos_t pos;

  logic signed [lmc_pkg::SampleW-1:0] upper_mem  [lmc_pkg::MaxCols];
  logic signed [lmc_pkg::SampleW-1:0] middle_mem [lmc_pkg::MaxCols];
  logic signed [lmc_pkg::SampleW-1:0] up_rd_q, mid_rd_q;
  logic signed [lmc_pkg::SampleW-1:0] fwd_up_q, fwd_mid_q;
  logic signed [lmc_pkg::SampleW-1:0] up_val, mid_val;
  logic fwd_q;

  logic                               p1_v_q;
  logic signed [lmc_pkg::SampleW-1:0] p1_sample_q;
  logic [lmc_pkg::ColW-1:0]           p1_col_q;
  pos_t                               p1_pos_q;
  logic                               p2_v_q;
  pos_t                               p2_pos_q;

  logic signed [lmc_pkg::SampleW-1:0] win_q [9];

  logic dq_k1, dq_k2, dq_l1, dq_l2;
  logic ok_k1, ok_k2, ok_l1, ok_l2;

  // Position of the incoming sample.
  always_comb begin
    col_ext      = lmc_pkg::PosCmpW'(col_q);
    row_ext      = lmc_pkg::PosCmpW'(row_q);
    cols_ext     = lmc_pkg::PosCmpW'(cols_i);
    rows_ext     = lmc_pkg::PosCmpW'(rows_i);
    pos.r_ge1    = (row_q != '0);
    pos.r_ge2    = (row_q > lmc_pkg::RowW'(1));
    pos.c_ge1    = (col_q != '0);
    pos.c_ge2    = (col_q > lmc_pkg::ColW'(1));
    pos.last_col = ((col_ext + lmc_pkg::PosCmpW'(1)) >= cols_ext);
    pos.last_row = ((row_ext + lmc_pkg::PosCmpW'(1)) >= rows_ext);
    pos.c_in     = (col_ext < cols_ext);
    pos.cm1_in   = (col_ext <= cols_ext);
    col_d = col_q;
    row_d = row_q;
    if (pos.last_col && pos.last_row) begin
      col_d = '0;
      row_d = '0;
    end else if (pos.last_col) begin
      col_d = '0;
      row_d = row_q + lmc_pkg::RowW'(1);
    end else begin
      col_d = col_q + lmc_pkg::ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else begin
      if (acc_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      p1_v_q <= acc_i;
      p2_v_q <= p1_v_q;
      fwd_q  <= acc_i && p1_v_q && (p1_col_q == col_q);
    end
  end

  // Stage one payload and forwarded store data for back-to-back same-column hits.
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      p1_sample_q <= sample_i;
      p1_col_q    <= col_q;
      p1_pos_q    <= pos;
      fwd_up_q    <= mid_val;
      fwd_mid_q   <= p1_sample_q;
    end
    if (p1_v_q) begin
      p2_pos_q <= p1_pos_q;
    end
  end

  // Line stores: read at acceptance, written in the cycle after.
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      up_rd_q  <= upper_mem[col_q];
      mid_rd_q <= middle_mem[col_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_v_q) begin
      upper_mem[p1_col_q]  <= mid_val;
      middle_mem[p1_col_q] <= p1_sample_q;
    end
  end

  assign up_val  = fwd_q ? fwd_up_q : up_rd_q;
  assign mid_val = fwd_q ? fwd_mid_q : mid_rd_q;

  // Window: entry i*3+j is row i (oldest first), column j (oldest first).
  always_ff @(posedge clk_i) begin
    if (p1_v_q) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= up_val;
      win_q[5] <= mid_val;
      win_q[8] <= p1_sample_q;
    end
  end

  // Judge centres; a neighbour disqualifies only when strictly greater.
  always_comb begin
    // Row above, column to the left of the newest.
    dq_k1 = (p2_pos_q.r_ge2 && ((p2_pos_q.c_ge2 && (win_q[0] > win_q[4])) ||
                                 (win_q[1] > win_q[4]) ||
                                 (p2_pos_q.c_in && (win_q[2] > win_q[4])))) ||
            (p2_pos_q.c_ge2 && (win_q[3] > win_q[4])) ||
            (p2_pos_q.c_in && (win_q[5] > win_q[4])) ||
            (p2_pos_q.c_ge2 && (win_q[6] > win_q[4])) ||
            (win_q[7] > win_q[4]) ||
            (p2_pos_q.c_in && (win_q[8] > win_q[4]));
    ok_k1 = p2_pos_q.r_ge1 && p2_pos_q.c_ge1 && p2_pos_q.cm1_in && !dq_k1;
    // Row above, last column of the row.
    dq_k2 = (p2_pos_q.r_ge2 && ((p2_pos_q.c_ge1 && (win_q[1] > win_q[5])) ||
                                 (win_q[2] > win_q[5]))) ||
            (p2_pos_q.c_ge1 && (win_q[4] > win_q[5])) ||
            (p2_pos_q.c_ge1 && (win_q[7] > win_q[5])) ||
            (win_q[8] > win_q[5]);
    ok_k2 = p2_pos_q.r_ge1 && p2_pos_q.last_col && p2_pos_q.c_in && !dq_k2;
    // Current row as a possible final row: no row below.
    dq_l1 = (p2_pos_q.r_ge1 && ((p2_pos_q.c_ge2 && (win_q[3] > win_q[7])) ||
                                 (win_q[4] > win_q[7]) ||
                                 (p2_pos_q.c_in && (win_q[5] > win_q[7])))) ||
            (p2_pos_q.c_ge2 && (win_q[6] > win_q[7])) ||
            (p2_pos_q.c_in && (win_q[8] > win_q[7]));
    ok_l1 = p2_pos_q.c_ge1 && p2_pos_q.cm1_in && !dq_l1;
    dq_l2 = (p2_pos_q.r_ge1 && ((p2_pos_q.c_ge1 && (win_q[4] > win_q[8])) ||
                                 (win_q[5] > win_q[8]))) ||
            (p2_pos_q.c_ge1 && (win_q[7] > win_q[8]));
    ok_l2 = p2_pos_q.last_col && p2_pos_q.c_in && !dq_l2;

    rec_o.frame_end = p2_pos_q.last_col && p2_pos_q.last_row;
    rec_o.row_end   = p2_pos_q.last_col;
    rec_o.inc_win   = 2'({1'b0, ok_k1} + {1'b0, ok_k2});
    rec_o.inc_last  = 2'({1'b0, ok_l1} + {1'b0, ok_l2});
  end

  assign push_o     = p2_v_q;
  assign inflight_o = 2'({1'b0, p1_v_q} + {1'b0, p2_v_q});

endmodule

/* rtl/core/lmc_queue.sv */
// Short flop queue of decided items between the front end and the counter.
module lmc_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  lmc_pkg::rec_t             rec_i,
  input  logic                      pop_i,
  output logic                      valid_o,
  output lmc_pkg::rec_t             rec_o,
  output logic [lmc_pkg::QCntW-1:0] count_o
);

  lmc_pkg::rec_t             buf_q [lmc_pkg::QDepth];
  logic [lmc_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [lmc_pkg::QCntW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + lmc_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + lmc_pkg::QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + lmc_pkg::QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - lmc_pkg::QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= rec_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign rec_o   = buf_q[rd_q];
  assign count_o = count_q;

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != lmc_pkg::QCntW'(lmc_pkg::QDepth)) || pop_i)
    else $error("queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue read while empty");

  a_count_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + lmc_pkg::QCntW'(1)))
    else $error("queue fill count lost a write");

endmodule

/* rtl/core/lmc_back.sv */
// Back end: accumulate per-frame maxima and hold the result for the output stream.
module lmc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  lmc_pkg::rec_t              rec_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  output logic [lmc_pkg::CountW-1:0] out_count_o,
  input  logic                       out_ready_i
);

  logic [lmc_pkg::CountW-1:0] run_q, lrow_q, out_q;
  logic [lmc_pkg::CountW-1:0] run_sum, total;
  logic                       out_v_q;

  assign pop_o   = valid_i && (!rec_i.frame_end || !out_v_q || out_ready_i);
  assign run_sum = run_q + lmc_pkg::CountW'(rec_i.inc_win);
  assign total   = run_sum + lrow_q + lmc_pkg::CountW'(rec_i.inc_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      lrow_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (pop_o && rec_i.frame_end) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
      if (pop_o) begin
        if (rec_i.frame_end) begin
          run_q  <= '0;
          lrow_q <= '0;
        end else if (rec_i.row_end) begin
          run_q  <= run_sum;
          lrow_q <= '0;
        end else begin
          run_q  <= run_sum;
          lrow_q <= lrow_q + lmc_pkg::CountW'(rec_i.inc_last);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && rec_i.frame_end) begin
      out_q <= total;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_count_o = out_q;

endmodule

/* rtl/core/local_maxima_counter_3x3_core.sv */
// Top level of the 3x3 local-maximum counter: config registers, front end, queue, counter.
//
// The block takes one frame of num_rows x num_cols signed samples in row-major order, one
// sample per stream transaction, and emits one transaction per frame carrying the number of
// samples that have no strictly greater neighbor among their up to eight neighbors (samples
// outside the frame do not count as neighbors). It takes one sample per clock while the
// decision queue has room: each sample costs one read of each of the two line stores and
// one write of each in the cycle after, and the up to four centers it settles are compared
// in parallel. A sample passes the two window stages before it enters the decision queue
// and can leave it in the cycle after; the frame result is offered on the output from the
// cycle after the last sample leaves the queue. The input side keeps accepting while a
// finished result waits for the output side, until the decision queue and the two window
// stages together hold four samples. The line stores need no clearing after reset; change
// num_rows and num_cols only between frames. Register 0 is num_rows and register 1 is
// num_cols (both 1..512, 0 acts as 1, larger values act as 512); both reset to 512.
module local_maxima_counter_3x3_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,   // [15:0] sample
  // Result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [lmc_pkg::OutW-1:0]    m_axis_tdata,   // [18:0] maxima_count, rest zero
  // Configuration writes
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [lmc_pkg::CfgW-1:0]    cfg_wdata_i
);

  logic [lmc_pkg::CfgW-1:0]   num_rows_q, num_cols_q;
  logic [lmc_pkg::CfgW-1:0]   eff_rows, eff_cols;
  logic                       accept;
  logic                       push, pop, q_valid;
  lmc_pkg::rec_t              rec_in, rec_out;
  logic [lmc_pkg::QCntW-1:0]  q_count;
  logic [1:0]                 inflight;
  logic [lmc_pkg::QCntW:0]    occupancy;
  logic [lmc_pkg::CountW-1:0] out_count;

  // Hold the size registers; the user must write them only between frames, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= lmc_pkg::CfgW'(lmc_pkg::MaxRows);
      num_cols_q <= lmc_pkg::CfgW'(lmc_pkg::MaxCols);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmc_pkg::RegNumRows: num_rows_q <= cfg_wdata_i;
        lmc_pkg::RegNumCols: num_cols_q <= cfg_wdata_i;
        default:             ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, oversize acts as the store capacity.
  always_comb begin
    if (num_rows_q == '0) begin
      eff_rows = lmc_pkg::CfgW'(1);
    end else if (num_rows_q > lmc_pkg::CfgW'(lmc_pkg::MaxRows)) begin
      eff_rows = lmc_pkg::CfgW'(lmc_pkg::MaxRows);
    end else begin
      eff_rows = num_rows_q;
    end
    if (num_cols_q == '0) begin
      eff_cols = lmc_pkg::CfgW'(1);
    end else if (num_cols_q > lmc_pkg::CfgW'(lmc_pkg::MaxCols)) begin
      eff_cols = lmc_pkg::CfgW'(lmc_pkg::MaxCols);
    end else begin
      eff_cols = num_cols_q;
    end
  end

  // Accept only while every sample in flight is sure of a queue slot.
  assign occupancy     = (lmc_pkg::QCntW+1)'(q_count) + (lmc_pkg::QCntW+1)'(inflight);
  assign s_axis_tready = (occupancy < (lmc_pkg::QCntW+1)'(lmc_pkg::QDepth));
  assign accept        = s_axis_tvalid && s_axis_tready;

  lmc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (accept),
    .sample_i   (s_axis_tdata[lmc_pkg::SampleW-1:0]),
    .rows_i     (eff_rows),
    .cols_i     (eff_cols),
    .push_o     (push),
    .rec_o      (rec_in),
    .inflight_o (inflight)
  );

  lmc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (rec_out),
    .count_o (q_count)
  );

  lmc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_count_o (out_count),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = lmc_pkg::OutW'(out_count);

endmodule
